// File: sv/mssd_pkg.sv
// Shared types and constants for the masked SSD template match unit.
// No dependencies; mssd_sqacc and the top module import this package.
`timescale 1ns / 1ps

package mssd_pkg;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 6;
	localparam int TDIM_W  = 5;
	localparam int SDIM_W  = 7;
	localparam int CFG_W   = 7;
	localparam int SQ_W    = 16;
	localparam int SCORE_W = 24;

	localparam logic [1:0] CFG_TMPL_ROWS = 2'd0;
	localparam logic [1:0] CFG_TMPL_COLS = 2'd1;
	localparam logic [1:0] CFG_SRCH_ROWS = 2'd2;
	localparam logic [1:0] CFG_SRCH_COLS = 2'd3;

	typedef enum logic [1:0] {
		FN_LOAD_TMPL = 2'd0,
		FN_LOAD_SRCH = 2'd1,
		FN_QUERY     = 2'd2
	} mssd_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} mssd_state_t;

	// Qualifiers that travel alongside the memory read data.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mssd_ctl_t;

endpackage

// File: sv/mssd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/mssd_sqacc.sv
// Square-and-accumulate pipeline fed by the template and search memory reads.
// Depends on mssd_pkg for the control struct and widths.
`timescale 1ns / 1ps

module mssd_sqacc
	import mssd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mssd_ctl_t          ctl,
	input  logic [PIX_W-1:0]   tpix,
	input  logic               tmask,
	input  logic [PIX_W-1:0]   spix,
	output logic [SCORE_W-1:0] sum,
	output logic               done
);

	logic [PIX_W-1:0]   absdiff;
	logic [SQ_W-1:0]    sq_s2;
	mssd_ctl_t          ctl_s2;
	logic [SCORE_W:0]   acc_next;
	logic [SCORE_W-1:0] acc_q;
	logic               done_q;

	assign absdiff = (tpix >= spix) ? (tpix - spix) : (spix - tpix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2 <= tmask ? (SQ_W'(absdiff) * SQ_W'(absdiff)) : '0;
	end

	// Saturating each step equals saturating the final sum, as all terms are non-negative.
	assign acc_next = (ctl_s2.first ? {(SCORE_W+1){1'b0}} : {1'b0, acc_q})
		+ (SCORE_W+1)'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.vld && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= acc_next[SCORE_W] ? {SCORE_W{1'b1}} : acc_next[SCORE_W-1:0];
		end
	end

	assign sum  = acc_q;
	assign done = done_q;

endmodule

// File: sv/masked_ssd_template_match_unit.sv
// Masked sum-of-squared-differences template matcher on 8-bit gray images.
// A query at a valid offset scans the template: the scan reads one template
// position per cycle from the template and search memory read ports, and the
// square-and-accumulate pipeline then drains. A query whose template overruns
// the search area skips the scan and returns offset_error with score 0. While
// a query runs the input is stalled; a finished result waits in the output
// register while further loads are taken.
`timescale 1ns / 1ps

module masked_ssd_template_match_unit
	import mssd_pkg::*;
#(
	parameter int MAX_TEMPLATE_ROWS = 16,
	parameter int MAX_TEMPLATE_COLS = 16,
	parameter int MAX_SEARCH_ROWS   = 64,
	parameter int MAX_SEARCH_COLS   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               mask_bit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SCORE_W-1:0] score,
	output logic               offset_error
);

	localparam int T_DEPTH = MAX_TEMPLATE_ROWS * MAX_TEMPLATE_COLS;
	localparam int S_DEPTH = MAX_SEARCH_ROWS * MAX_SEARCH_COLS;
	localparam int TA_W = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
	localparam int SA_W = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
	localparam logic [TDIM_W-1:0] TR_RST =
		TDIM_W'((MAX_TEMPLATE_ROWS < 16) ? MAX_TEMPLATE_ROWS : 16);
	localparam logic [TDIM_W-1:0] TC_RST =
		TDIM_W'((MAX_TEMPLATE_COLS < 16) ? MAX_TEMPLATE_COLS : 16);
	localparam logic [SDIM_W-1:0] SR_RST =
		SDIM_W'((MAX_SEARCH_ROWS < 64) ? MAX_SEARCH_ROWS : 64);
	localparam logic [SDIM_W-1:0] SC_RST =
		SDIM_W'((MAX_SEARCH_COLS < 64) ? MAX_SEARCH_COLS : 64);

	function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int maxv);
		logic [CFG_W-1:0] res;
		if (v == '0) begin
			res = CFG_W'(1);
		end else if (int'(v) > maxv) begin
			res = CFG_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	logic [TDIM_W-1:0] tr_q, tc_q;
	logic [SDIM_W-1:0] sr_q, sc_q;

	mssd_state_t state_q, state_d;
	logic        in_acc, is_query, overrun, last_pos, out_free;
	logic        err_q;
	logic [TDIM_W-1:0] r_q, c_q;
	logic [TA_W-1:0]   t_base_q, t_raddr;
	logic [SA_W-1:0]   s_base_q, s_raddr;
	mssd_ctl_t   ctl_s1;

	logic              t_we, s_we;
	logic [TA_W-1:0]   t_waddr;
	logic [SA_W-1:0]   s_waddr;
	logic [PIX_W:0]    t_rdata;
	logic [PIX_W-1:0]  s_rdata;
	logic [SCORE_W-1:0] acc_sum;
	logic              acc_done;

	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;
	logic               offset_error_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q <= TR_RST;
			tc_q <= TC_RST;
			sr_q <= SR_RST;
			sc_q <= SC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TMPL_ROWS: tr_q <= TDIM_W'(clamp_size(CFG_W'(cfg_data[TDIM_W-1:0]),
					MAX_TEMPLATE_ROWS));
				CFG_TMPL_COLS: tc_q <= TDIM_W'(clamp_size(CFG_W'(cfg_data[TDIM_W-1:0]),
					MAX_TEMPLATE_COLS));
				CFG_SRCH_ROWS: sr_q <= clamp_size(cfg_data, MAX_SEARCH_ROWS);
				CFG_SRCH_COLS: sc_q <= clamp_size(cfg_data, MAX_SEARCH_COLS);
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_query = (func == FN_QUERY);
	assign overrun  = ((8'(row) + 8'(tr_q)) > 8'(sr_q)) || ((8'(col) + 8'(tc_q)) > 8'(sc_q));
	assign last_pos = (r_q == tr_q - TDIM_W'(1)) && (c_q == tc_q - TDIM_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	// Load writes; the memory read data is used only while the input is stalled.
	assign t_we = in_acc && (func == FN_LOAD_TMPL)
		&& (int'(row) < MAX_TEMPLATE_ROWS) && (int'(col) < MAX_TEMPLATE_COLS);
	assign s_we = in_acc && (func == FN_LOAD_SRCH)
		&& (int'(row) < MAX_SEARCH_ROWS) && (int'(col) < MAX_SEARCH_COLS);
	assign t_waddr = TA_W'(int'(row) * MAX_TEMPLATE_COLS + int'(col));
	assign s_waddr = SA_W'(int'(row) * MAX_SEARCH_COLS + int'(col));
	assign t_raddr = t_base_q + TA_W'(c_q);
	assign s_raddr = s_base_q + SA_W'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_query) begin
					state_d = overrun ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_pos) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (acc_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Scan counters and row base addresses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q      <= '0;
			c_q      <= '0;
			t_base_q <= '0;
			s_base_q <= '0;
			err_q    <= 1'b0;
			ctl_s1   <= '0;
		end else begin
			ctl_s1.vld   <= (state_q == ST_SCAN);
			ctl_s1.first <= (r_q == '0) && (c_q == '0);
			ctl_s1.last  <= last_pos;
			if (in_acc && is_query) begin
				r_q      <= '0;
				c_q      <= '0;
				t_base_q <= '0;
				s_base_q <= SA_W'(int'(row) * MAX_SEARCH_COLS + int'(col));
				err_q    <= overrun;
			end else if (state_q == ST_SCAN) begin
				if (c_q == tc_q - TDIM_W'(1)) begin
					c_q      <= '0;
					r_q      <= r_q + TDIM_W'(1);
					t_base_q <= t_base_q + TA_W'(MAX_TEMPLATE_COLS);
					s_base_q <= s_base_q + SA_W'(MAX_SEARCH_COLS);
				end else begin
					c_q <= c_q + TDIM_W'(1);
				end
			end
		end
	end

	mssd_ram #(
		.WIDTH (PIX_W + 1),
		.DEPTH (T_DEPTH)
	) u_tmpl_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata ({mask_bit, pixel}),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	mssd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (S_DEPTH)
	) u_srch_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (pixel),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	mssd_sqacc u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.tpix   (t_rdata[PIX_W-1:0]),
		.tmask  (t_rdata[PIX_W]),
		.spix   (s_rdata),
		.sum    (acc_sum),
		.done   (acc_done)
	);

	// Output register: holds a finished result until the receiver takes the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			score_q        <= err_q ? '0 : acc_sum;
			offset_error_q <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign score        = score_q;
	assign offset_error = offset_error_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> (state_q == ST_DRAIN))
		else $error("accumulator finished outside the drain phase");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (func == FN_QUERY)) |=> (state_q != ST_IDLE))
		else $error("accepted query did not start");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((r_q < tr_q) && (c_q < tc_q)))
		else $error("scan position beyond template size");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && offset_error_q) |-> (score_q == '0))
		else $error("offset error result carries a nonzero score");

endmodule
